// ----- rtl/lsog_pkg.sv -----
// ----------------------------------------------------------------------------
// lsog_pkg
// shared types, codes and constants of the least-squares objective and
// gradient core
// ----------------------------------------------------------------------------
package lsog_pkg;

  // default store sizes
  localparam int LSOG_MAX_ROWS = 32;
  localparam int LSOG_MAX_COLS = 16;

  // fixed field widths
  localparam int DATA_W   = 32;
  localparam int RESULT_W = 64;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 4;
  localparam int IDX_W    = 4;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 5;
  localparam int MODE_W   = 2;

  // packed stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  // reset values of the count registers
  localparam logic [ROWS_CFG_W-1:0] ROWS_CFG_RESET = 6'd32;
  localparam logic [COLS_CFG_W-1:0] COLS_CFG_RESET = 5'd16;

  // target scale to Q32.32, negated, and the residual rounding bias
  localparam logic signed [DATA_W-1:0] NEG_SCALE = -32'sd65536;
  localparam int ROUND_BIAS = 32768;

  // result kinds
  localparam logic KIND_OBJ  = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  // input beat modes
  typedef enum logic [MODE_W-1:0] {
    MODE_MAT  = 2'd0,
    MODE_TGT  = 2'd1,
    MODE_PT   = 2'd2,
    MODE_EVAL = 2'd3
  } mode_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  // operand pairs of the shared multiplier
  typedef enum logic [1:0] {
    OP_MAT_PT    = 2'd0,
    OP_TGT_SCALE = 2'd1,
    OP_RES_SQ    = 2'd2,
    OP_RES_MAT   = 2'd3
  } opsel_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_RD,
    S_RES_MUL,
    S_RES_ACC,
    S_TGT_RD,
    S_TGT_MUL,
    S_TGT_ACC,
    S_RND,
    S_SQ_MUL,
    S_SQ_ACC,
    S_OBJ_PUT,
    S_GRD_RD,
    S_GRD_MUL,
    S_GRD_ACC,
    S_GRD_PUT
  } lsog_state_t;

  // controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    opsel_t op_sel;
    logic   mul_en;
    logic   acc_zero;
    logic   acc_round;
    logic   acc_en;
    logic   obj_clr;
    logic   obj_en;
    logic   res_en;
  } mac_ctl_t;

endpackage

// ----- rtl/lsog_ram.sv -----
// ----------------------------------------------------------------------------
// lsog_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lsog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lsog_mac.sv -----
// ----------------------------------------------------------------------------
// lsog_mac
// shared 32x32 multiplier with the row, objective and gradient accumulators
// and the rounding and saturation of their results
// ----------------------------------------------------------------------------
module lsog_mac
  import lsog_pkg::*;
#(
  parameter int ACC_W = 77
) (
  input  logic                       clk,
  input  mac_ctl_t                   ctl,
  input  logic signed [DATA_W-1:0]   mat_q,
  input  logic signed [DATA_W-1:0]   pt_q,
  input  logic signed [DATA_W-1:0]   tgt_q,
  input  logic signed [DATA_W-1:0]   rsd_q,
  output logic signed [DATA_W-1:0]   res_sat,
  output logic signed [RESULT_W-1:0] obj_sat,
  output logic signed [RESULT_W-1:0] grad_sat
);

  localparam logic signed [DATA_W-1:0]   S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0]   S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [RESULT_W-1:0] S64_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
  localparam logic signed [RESULT_W-1:0] S64_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

  logic signed [DATA_W-1:0]   op_a;
  logic signed [DATA_W-1:0]   op_b;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    obj_r;
  logic signed [DATA_W-1:0]   res_r;

  // operand select for the shared multiplier
  always_comb begin
    case (ctl.op_sel)
      OP_MAT_PT: begin
        op_a = mat_q;
        op_b = pt_q;
      end
      OP_TGT_SCALE: begin
        op_a = tgt_q;
        op_b = NEG_SCALE;
      end
      OP_RES_SQ: begin
        op_a = res_r;
        op_b = res_r;
      end
      OP_RES_MAT: begin
        op_a = rsd_q;
        op_b = mat_q;
      end
      default: begin
        op_a = mat_q;
        op_b = pt_q;
      end
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod_ext = {{(ACC_W-2*DATA_W){prod_r[2*DATA_W-1]}}, prod_r};

  // row and gradient accumulator
  always_ff @(posedge clk) begin
    if (ctl.acc_zero) begin
      acc_r <= '0;
    end else if (ctl.acc_round) begin
      acc_r <= ACC_W'(ROUND_BIAS);
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  // objective accumulator
  always_ff @(posedge clk) begin
    if (ctl.obj_clr) begin
      obj_r <= '0;
    end else if (ctl.obj_en) begin
      obj_r <= obj_r + prod_ext;
    end
  end

  // residual: drop 16 fraction bits, saturate to 32 bits
  always_comb begin
    if ((&acc_r[ACC_W-1:47]) || !(|acc_r[ACC_W-1:47])) begin
      res_sat = acc_r[47:16];
    end else if (acc_r[ACC_W-1]) begin
      res_sat = S32_MIN;
    end else begin
      res_sat = S32_MAX;
    end
  end

  // residual held for squaring
  always_ff @(posedge clk) begin
    if (ctl.res_en) begin
      res_r <= res_sat;
    end
  end

  // objective saturated to 64 bits
  always_comb begin
    if ((&obj_r[ACC_W-1:63]) || !(|obj_r[ACC_W-1:63])) begin
      obj_sat = obj_r[63:0];
    end else if (obj_r[ACC_W-1]) begin
      obj_sat = S64_MIN;
    end else begin
      obj_sat = S64_MAX;
    end
  end

  // doubled gradient sum saturated to 64 bits
  always_comb begin
    if ((&acc_r[ACC_W-1:62]) || !(|acc_r[ACC_W-1:62])) begin
      grad_sat = {acc_r[62:0], 1'b0};
    end else if (acc_r[ACC_W-1]) begin
      grad_sat = S64_MIN;
    end else begin
      grad_sat = S64_MAX;
    end
  end

endmodule

// ----- rtl/lsog_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsog_ctrl
// sequencer: store writes for load beats, row and column walk of an
// evaluate beat, multiply-accumulate controls and the result register
// ----------------------------------------------------------------------------
module lsog_ctrl
  import lsog_pkg::*;
#(
  parameter int MAX_ROWS = LSOG_MAX_ROWS,
  parameter int MAX_COLS = LSOG_MAX_COLS,
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int MAW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  mode_t                 in_mode,
  input  logic [ROW_W-1:0]      in_row,
  input  logic [COL_W-1:0]      in_col,
  // counts
  input  logic [ROWS_CFG_W-1:0] rows_cfg,
  input  logic [COLS_CFG_W-1:0] cols_cfg,
  // store ports
  output logic                  mat_we,
  output logic [MAW-1:0]        mat_waddr,
  output logic [MAW-1:0]        mat_raddr,
  output logic                  tgt_we,
  output logic [RIW-1:0]        tgt_waddr,
  output logic                  pt_we,
  output logic [CIW-1:0]        pt_waddr,
  output logic                  rsd_we,
  output logic [RIW-1:0]        row_addr,
  output logic [CIW-1:0]        col_addr,
  // multiply-accumulate unit
  output mac_ctl_t              mac_ctl,
  input  logic [RESULT_W-1:0]   obj_sat,
  input  logic [RESULT_W-1:0]   grad_sat,
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_kind,
  output logic [IDX_W-1:0]      out_index,
  output logic [RESULT_W-1:0]   out_value,
  output logic                  out_last
);

  lsog_state_t state_r, state_nxt;

  logic [RIW-1:0] i_r, i_nxt;
  logic [CIW-1:0] j_r, j_nxt;
  logic [RIW-1:0] rows_last_r, rows_last_nxt;
  logic [CIW-1:0] cols_last_r, cols_last_nxt;
  logic [RIW-1:0] rows_last;
  logic [CIW-1:0] cols_last;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]    out_index_r, out_index_nxt;
  logic [RESULT_W-1:0] out_value_r, out_value_nxt;
  logic                out_last_r, out_last_nxt;

  logic in_accept;
  logic out_free;
  logic row_end;
  logic col_end;
  logic row_ok;
  logic col_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign row_end   = (i_r == rows_last_r);
  assign col_end   = (j_r == cols_last_r);
  assign row_ok    = (int'(in_row) < MAX_ROWS);
  assign col_ok    = (int'(in_col) < MAX_COLS);

  // clamp the counts to 1 .. max, kept as last index
  always_comb begin
    if (rows_cfg == '0) begin
      rows_last = '0;
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      rows_last = RIW'(MAX_ROWS - 1);
    end else begin
      rows_last = RIW'(int'(rows_cfg) - 1);
    end
    if (cols_cfg == '0) begin
      cols_last = '0;
    end else if (int'(cols_cfg) > MAX_COLS) begin
      cols_last = CIW'(MAX_COLS - 1);
    end else begin
      cols_last = CIW'(int'(cols_cfg) - 1);
    end
  end

  // store addresses
  assign mat_waddr = MAW'(int'(in_row) * MAX_COLS + int'(in_col));
  assign mat_raddr = MAW'(int'(i_r) * MAX_COLS + int'(j_r));
  assign tgt_waddr = RIW'(in_row);
  assign pt_waddr  = CIW'(in_col);
  assign row_addr  = i_r;
  assign col_addr  = j_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_accept && in_mode == MODE_EVAL) state_nxt = S_RES_RD;
      S_RES_RD:  state_nxt = S_RES_MUL;
      S_RES_MUL: state_nxt = S_RES_ACC;
      S_RES_ACC: state_nxt = col_end ? S_TGT_RD : S_RES_RD;
      S_TGT_RD:  state_nxt = S_TGT_MUL;
      S_TGT_MUL: state_nxt = S_TGT_ACC;
      S_TGT_ACC: state_nxt = S_RND;
      S_RND:     state_nxt = S_SQ_MUL;
      S_SQ_MUL:  state_nxt = S_SQ_ACC;
      S_SQ_ACC:  state_nxt = row_end ? S_OBJ_PUT : S_RES_RD;
      S_OBJ_PUT: if (out_free) state_nxt = S_GRD_RD;
      S_GRD_RD:  state_nxt = S_GRD_MUL;
      S_GRD_MUL: state_nxt = S_GRD_ACC;
      S_GRD_ACC: state_nxt = row_end ? S_GRD_PUT : S_GRD_RD;
      S_GRD_PUT: if (out_free) state_nxt = col_end ? S_IDLE : S_GRD_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // outputs, counters and result register
  always_comb begin
    mac_ctl       = '0;
    mac_ctl.op_sel = OP_MAT_PT;
    mat_we        = 1'b0;
    tgt_we        = 1'b0;
    pt_we         = 1'b0;
    rsd_we        = 1'b0;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_mode)
            MODE_MAT: mat_we = row_ok && col_ok;
            MODE_TGT: tgt_we = row_ok;
            MODE_PT:  pt_we  = col_ok;
            MODE_EVAL: begin
              rows_last_nxt     = rows_last;
              cols_last_nxt     = cols_last;
              i_nxt             = '0;
              j_nxt             = '0;
              mac_ctl.acc_round = 1'b1;
              mac_ctl.obj_clr   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_RES_MUL: begin
        mac_ctl.op_sel = OP_MAT_PT;
        mac_ctl.mul_en = 1'b1;
      end
      S_RES_ACC: begin
        mac_ctl.acc_en = 1'b1;
        j_nxt = col_end ? '0 : j_r + 1'b1;
      end
      S_TGT_MUL: begin
        mac_ctl.op_sel = OP_TGT_SCALE;
        mac_ctl.mul_en = 1'b1;
      end
      S_TGT_ACC: mac_ctl.acc_en = 1'b1;
      S_RND: begin
        mac_ctl.res_en = 1'b1;
        rsd_we         = 1'b1;
      end
      S_SQ_MUL: begin
        mac_ctl.op_sel = OP_RES_SQ;
        mac_ctl.mul_en = 1'b1;
      end
      S_SQ_ACC: begin
        mac_ctl.obj_en = 1'b1;
        if (!row_end) begin
          i_nxt             = i_r + 1'b1;
          mac_ctl.acc_round = 1'b1;
        end
      end
      S_OBJ_PUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = KIND_OBJ;
          out_index_nxt    = '0;
          out_value_nxt    = obj_sat;
          out_last_nxt     = 1'b0;
          mac_ctl.acc_zero = 1'b1;
          i_nxt            = '0;
          j_nxt            = '0;
        end
      end
      S_GRD_MUL: begin
        mac_ctl.op_sel = OP_RES_MAT;
        mac_ctl.mul_en = 1'b1;
      end
      S_GRD_ACC: begin
        mac_ctl.acc_en = 1'b1;
        if (!row_end) begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_GRD_PUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = KIND_GRAD;
          out_index_nxt    = IDX_W'(j_r);
          out_value_nxt    = grad_sat;
          out_last_nxt     = col_end;
          mac_ctl.acc_zero = 1'b1;
          i_nxt            = '0;
          if (!col_end) begin
            j_nxt = j_r + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      rows_last_r <= '0;
      cols_last_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      rows_last_r <= rows_last_nxt;
      cols_last_r <= cols_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_index  = out_index_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

`ifndef SYNTH
  // a result beat only appears from one of the two put states
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OBJ_PUT || $past(state_r) == S_GRD_PUT))
    else $error("result beat raised outside a put state");

  // the last beat of a run is always a gradient component
  a_last_grad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_GRAD))
    else $error("last marked on objective beat");

  // leaving the final put loads a last-marked beat and returns to idle
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRD_PUT && out_free && col_end) |=>
      (out_valid_r && out_last_r && state_r == S_IDLE))
    else $error("run ended without last beat");

  // the walk never passes the latched row and column counts
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (i_r <= rows_last_r && j_r <= cols_last_r))
    else $error("row or column index beyond count");
`endif

endmodule

// ----- rtl/least_squares_objective_gradient_core.sv -----
// ----------------------------------------------------------------------------
// least_squares_objective_gradient_core
// residual, objective and gradient of a linear least-squares problem
// ----------------------------------------------------------------------------
// Load beats (tuser 0, 1, 2) write one entry of the matrix A, target y or
// point x, all signed Q16.16, and free the input again. An evaluate beat
// (tuser 3) forms v = A*x - y rounded to Q16.16, then sends the objective
// sum(v_i^2) followed by the gradient 2*(A^T v)_j for j = 0 .. cols-1, the
// last one marked by tlast; results are signed Q32.32 saturated to 64 bits.
// All products go through one shared 32x32 multiplier fed by registered
// store reads, so an evaluate beat occupies the block until its last
// result beat is loaded into the output register, output stalls included,
// with in_tready low meanwhile. rows_in_use and cols_in_use are clamped to
// 1 .. MAX_ROWS and 1 .. MAX_COLS; entries read by an evaluate must have
// been loaded first, and counts should only be written while idle.
// ----------------------------------------------------------------------------
module least_squares_objective_gradient_core
  import lsog_pkg::*;
#(
  parameter int MAX_ROWS = LSOG_MAX_ROWS,
  parameter int MAX_COLS = LSOG_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_addr,
  input  logic [ROWS_CFG_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // row_index[4:0], col_index[8:5], value[40:9]
  input  logic [MODE_W-1:0]     in_tuser,   // mode[1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // index[3:0], result_value[67:4]
  output logic                  out_tuser,  // kind[0]
  output logic                  out_tlast
);

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int MAW = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int ACC_W = 2 * DATA_W + 4 + $clog2(MAX_DIM + 1);

  logic [ROWS_CFG_W-1:0] rows_cfg_r;
  logic [COLS_CFG_W-1:0] cols_cfg_r;

  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [DATA_W-1:0] in_value;

  logic           mat_we, tgt_we, pt_we, rsd_we;
  logic [MAW-1:0] mat_waddr, mat_raddr;
  logic [RIW-1:0] tgt_waddr, row_addr;
  logic [CIW-1:0] pt_waddr, col_addr;

  logic [DATA_W-1:0]   mat_q, pt_q, tgt_q, rsd_q;
  logic [DATA_W-1:0]   res_sat;
  logic [RESULT_W-1:0] obj_sat, grad_sat;
  mac_ctl_t            mac_ctl;

  logic [IDX_W-1:0]    out_index;
  logic [RESULT_W-1:0] out_value;

  // count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_CFG_RESET;
      cols_cfg_r <= COLS_CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ROWS: rows_cfg_r <= cfg_wdata;
        CFG_COLS: cols_cfg_r <= cfg_wdata[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat fields
  assign in_row   = in_tdata[4:0];
  assign in_col   = in_tdata[8:5];
  assign in_value = in_tdata[40:9];

  // sequencer
  lsog_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_mode    (mode_t'(in_tuser)),
    .in_row     (in_row),
    .in_col     (in_col),
    .rows_cfg   (rows_cfg_r),
    .cols_cfg   (cols_cfg_r),
    .mat_we     (mat_we),
    .mat_waddr  (mat_waddr),
    .mat_raddr  (mat_raddr),
    .tgt_we     (tgt_we),
    .tgt_waddr  (tgt_waddr),
    .pt_we      (pt_we),
    .pt_waddr   (pt_waddr),
    .rsd_we     (rsd_we),
    .row_addr   (row_addr),
    .col_addr   (col_addr),
    .mac_ctl    (mac_ctl),
    .obj_sat    (obj_sat),
    .grad_sat   (grad_sat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_kind   (out_tuser),
    .out_index  (out_index),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  // matrix store
  lsog_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (in_value),
    .raddr (mat_raddr),
    .rdata (mat_q)
  );

  // target store
  lsog_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (tgt_waddr),
    .wdata (in_value),
    .raddr (row_addr),
    .rdata (tgt_q)
  );

  // point store
  lsog_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (in_value),
    .raddr (col_addr),
    .rdata (pt_q)
  );

  // residual store
  lsog_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ROWS)) u_rsd_ram (
    .clk   (clk),
    .we    (rsd_we),
    .waddr (row_addr),
    .wdata (res_sat),
    .raddr (row_addr),
    .rdata (rsd_q)
  );

  // shared multiply-accumulate unit
  lsog_mac #(.ACC_W(ACC_W)) u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .mat_q    (mat_q),
    .pt_q     (pt_q),
    .tgt_q    (tgt_q),
    .rsd_q    (rsd_q),
    .res_sat  (res_sat),
    .obj_sat  (obj_sat),
    .grad_sat (grad_sat)
  );

  // result beat packing
  assign out_tdata = {{(OUT_DATA_W-IDX_W-RESULT_W){1'b0}}, out_value, out_index};

endmodule
